// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  typedef logic [BYTE_W-1:0] byte_t;

  // request function codes
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_D_RDI = 10'b00_0000_0010,
    ST_D_RDJ = 10'b00_0000_0100,
    ST_D_SWI = 10'b00_0000_1000,
    ST_K_INI = 10'b00_0001_0000,
    ST_K_RDK = 10'b00_0010_0000,
    ST_K_RDJ = 10'b00_0100_0000,
    ST_K_SWK = 10'b00_1000_0000,
    ST_K_SWJ = 10'b01_0000_0000,
    ST_D_SWJ = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/rc4_if.sv =====
interface rc4_in_if;
  import rc4_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  byte_t in_byte;
  logic  last;

  modport source (output valid, output func, output in_byte, output last, input ready);
  modport sink   (input valid, input func, input in_byte, input last, output ready);
endinterface

interface rc4_out_if;
  import rc4_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/rc4_stream_cipher_core.sv =====
// channel   dir  handshake      payload
// in_chan   in   valid/ready    func, in_byte, last
// out_chan  out  valid/ready    out_byte, out_last
//
// key request: taken in idle; the key request marked last runs the key schedule,
//   a clear state then, per swap step, read k, read j, swap write k, swap write j
// data request: from request to the next ready the steps are read i, read j,
//   first swap write with keystream read, second swap write, result load;
//   at most one read and one write on the permutation memory a cycle
// reset (rst_n low, synchronous) restores the identity permutation at once
//   through per-entry valid bits; no clearing pass
// a held result on out_chan stalls the last data cycle until it is taken
module rc4_stream_cipher_core #(
  parameter int KEY_MAX = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  rc4_in_if.sink          in_chan,
  rc4_out_if.source       out_chan
);
  import rc4_pkg::*;

  // key store address, key count and permutation address widths
  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW   = $clog2(KEY_MAX + 1);
  localparam int PA_W = $clog2(PERM_DEPTH);

  state_t state_r, state_nxt;

  byte_t i_r, i_nxt;         // generator index i, also schedule step counter
  byte_t j_r, j_nxt;
  byte_t si_r, si_nxt;       // perm[i] (or perm[k] during schedule)
  byte_t sj_r, sj_nxt;       // perm[j], then the keystream byte
  byte_t t_r, t_nxt;         // keystream address
  byte_t byte_r, byte_nxt;   // data byte in flight
  logic  last_r, last_nxt;

  logic [CW-1:0]   key_count_r, key_count_nxt;
  logic [KA_W-1:0] kpos_r, kpos_nxt;
  logic [CW-1:0]   kpos_inc;

  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_last_r, out_last_nxt;

  // permutation memory, valid bits give identity for unwritten entries
  logic [PERM_DEPTH-1:0] pv_r;
  logic                  pv_clr;
  logic                  rd_vld_r;
  byte_t                 rd_addr_r;

  logic             p_we, p_re;
  logic [PA_W-1:0]  p_waddr, p_raddr;
  byte_t            p_wdata, p_q, prd;

  logic             k_we, k_re;
  logic [KA_W-1:0]  k_raddr;
  byte_t            k_q;

  byte_t ks;
  logic  in_fire, out_free;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_last = out_last_r;

  // entry never written since reset or schedule start reads as its index
  assign prd = rd_vld_r ? p_q : rd_addr_r;

  // keystream byte after the swap: perm[j] now holds si, perm[i] holds sj
  assign ks = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : prd);

  assign kpos_inc = CW'(kpos_r) + CW'(1);

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
    .clk      (clk),
    .we       (p_we),
    .waddr    (p_waddr),
    .wdata    (p_wdata),
    .re       (p_re),
    .raddr    (p_raddr),
    .rd_data_r(p_q)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX)) u_key (
    .clk      (clk),
    .we       (k_we),
    .waddr    (key_count_r[KA_W-1:0]),
    .wdata    (in_chan.in_byte),
    .re       (k_re),
    .raddr    (k_raddr),
    .rd_data_r(k_q)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    key_count_nxt = key_count_r;
    kpos_nxt      = kpos_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    pv_clr        = 1'b0;
    p_we          = 1'b0;
    p_waddr       = i_r;
    p_wdata       = prd;
    p_re          = 1'b0;
    p_raddr       = i_r;
    k_we          = 1'b0;
    k_re          = 1'b0;
    k_raddr       = kpos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_chan.in_byte;
          last_nxt = in_chan.last;
          if (in_chan.func == FUNC_DATA) begin
            // advance i and fetch perm[i]
            i_nxt     = i_r + 8'd1;
            p_re      = 1'b1;
            p_raddr   = i_r + 8'd1;
            state_nxt = ST_D_RDI;
          end else begin
            // key bytes past the store depth are dropped
            if (key_count_r < CW'(KEY_MAX)) begin
              k_we          = 1'b1;
              key_count_nxt = key_count_r + CW'(1);
            end
            if (in_chan.last) begin
              state_nxt = ST_K_INI;
            end
          end
        end
      end
      ST_D_RDI: begin
        si_nxt    = prd;
        j_nxt     = j_r + prd;
        p_re      = 1'b1;
        p_raddr   = j_r + prd;
        state_nxt = ST_D_RDJ;
      end
      ST_D_RDJ: begin
        // first swap write, keystream read issued alongside
        sj_nxt    = prd;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = prd;
        t_nxt     = si_r + prd;
        p_re      = 1'b1;
        p_raddr   = si_r + prd;
        state_nxt = ST_D_SWI;
      end
      ST_D_SWI: begin
        // second swap write, keystream read data arrives
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = si_r;
        sj_nxt    = ks;
        state_nxt = ST_D_SWJ;
      end
      ST_D_SWJ: begin
        // result waits here until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r ^ sj_r;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_K_INI: begin
        // identity permutation through the valid bits
        pv_clr    = 1'b1;
        i_nxt     = '0;
        j_nxt     = '0;
        kpos_nxt  = '0;
        state_nxt = ST_K_RDK;
      end
      ST_K_RDK: begin
        p_re      = 1'b1;
        p_raddr   = i_r;
        k_re      = 1'b1;
        k_raddr   = kpos_r;
        state_nxt = ST_K_RDJ;
      end
      ST_K_RDJ: begin
        si_nxt    = prd;
        j_nxt     = j_r + prd + k_q;
        p_re      = 1'b1;
        p_raddr   = j_r + prd + k_q;
        state_nxt = ST_K_SWK;
      end
      ST_K_SWK: begin
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = prd;
        state_nxt = ST_K_SWJ;
      end
      ST_K_SWJ: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
        i_nxt   = i_r + 8'd1;
        // cycle through the stored key bytes
        if (kpos_inc >= key_count_r) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_inc[KA_W-1:0];
        end
        if (i_r == 8'hFF) begin
          // schedule done, i wraps to zero on its own
          j_nxt         = '0;
          key_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_K_RDK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      kpos_r      <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_count_r <= key_count_nxt;
      kpos_r      <= kpos_nxt;
      out_valid_r <= out_valid_nxt;
      if (pv_clr) begin
        pv_r <= '0;
      end else if (p_we) begin
        pv_r[p_waddr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    // valid bit and address follow the registered read of perm
    if (p_re) begin
      rd_vld_r  <= pv_r[p_raddr];
      rd_addr_r <= p_raddr;
    end
  end

  // a new result only comes out of the last data cycle
  a_out_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_D_SWJ)
    else $error("result raised outside the data sequence");

  // a finished schedule leaves i, j and the key count cleared
  a_sched_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_K_SWJ && state_r == ST_IDLE)
      |-> (i_r == '0 && j_r == '0 && key_count_r == '0))
    else $error("schedule end left stale indices");

  // key count never runs past the store depth
  a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CW'(KEY_MAX))
    else $error("key count overflow");

  // a key request never produces a result
  a_key_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.func == FUNC_KEY) |=> !$rose(out_valid_r))
    else $error("result after key request");

endmodule
